[rtl/button_typematic_repeat_assert.svh]
// assertion macros for the typematic repeat block
`ifndef BUTTON_TYPEMATIC_REPEAT_ASSERT_SVH
`define BUTTON_TYPEMATIC_REPEAT_ASSERT_SVH

// same-cycle implication, checked at every rising clock outside reset
`define BTR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BTR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/btr_pkg.sv]
package btr_pkg;

   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned CountWidth   = 18;
   localparam int unsigned DelayWidth   = 16;
   localparam int unsigned ButtonWidth  = 4;
   localparam int unsigned ReqDataWidth = 56;
   localparam int unsigned RspDataWidth = 64;

   localparam logic [DelayWidth-1:0] DefaultDelay = 16'd200;
   localparam logic [CountWidth-1:0] DefaultCount = 18'd200;

   typedef enum logic {
      OP_POLL  = 1'b0,
      OP_DELAY = 1'b1
   } op_type;

   // packed with the first field in the highest bits
   typedef struct packed {
      logic [2:0]             pad;
      logic [DelayWidth-1:0]  delay_value;
      logic [ButtonWidth-1:0] delay_button;
      logic                   freeze_baseline;
      logic [15:0]            elapsed_ms;
      logic [SampleWidth-1:0] pressed_buttons;
   } req_data_type;

   typedef struct packed {
      logic [SampleWidth-1:0] held_buttons;
      logic [SampleWidth-1:0] key_off_events;
      logic [SampleWidth-1:0] key_on_events;
      logic [SampleWidth-1:0] repeat_events;
   } rsp_data_type;

endpackage

[rtl/button_typematic_repeat.sv]
// results are registered: a taken request's result goes to the output register, or to the skid register while stalled
// throughput: one request beat per cycle while the skid register is empty, a two-deep result buffer absorbs one stall
// all lane counters and edge logic sit between the state registers and the result register
// reset (synchronous, active high): samples, baseline and freeze cleared,
// every delay and countdown set to 200 ms, no result pending
`include "button_typematic_repeat_assert.svh"

module button_typematic_repeat #(
   parameter int NUM_BUTTONS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pressed_buttons, elapsed_ms, freeze_baseline, delay_button, delay_value, zero pad
   input  logic [btr_pkg::ReqDataWidth-1:0]   req_tdata,
   // op
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // repeat_events, key_on_events, key_off_events, held_buttons
   output logic [btr_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import btr_pkg::*;

   localparam int NumLanes = (NUM_BUTTONS < int'(SampleWidth)) ? NUM_BUTTONS
                                                                : int'(SampleWidth);

   req_data_type           req;
   op_type                 op;
   logic                   req_take;
   rsp_data_type           result;

   logic [SampleWidth-1:0] current_ff,  current_in;
   logic [SampleWidth-1:0] baseline_ff, baseline_in;
   logic                   frozen_ff,   frozen_in;
   logic [CountWidth-1:0]  count_ff [NumLanes];
   logic [CountWidth-1:0]  count_in [NumLanes];
   logic [DelayWidth-1:0]  delay_ff [NumLanes];
   logic [DelayWidth-1:0]  delay_in [NumLanes];

   logic                   out_valid_ff,  out_valid_in;
   rsp_data_type           out_data_ff,   out_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   rsp_data_type           skid_data_ff,  skid_data_in;

   assign req        = req_data_type'(req_tdata);
   assign op         = op_type'(req_tuser);
   assign req_tready = !skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RspDataWidth'(out_data_ff);

   // lane logic
   always_comb begin
      logic [SampleWidth-1:0] sample;
      logic [SampleWidth-1:0] base;
      logic [SampleWidth-1:0] rising;
      logic [SampleWidth-1:0] fired;
      logic [CountWidth-1:0]  first;
      logic [CountWidth-1:0]  elapsed;
      logic [CountWidth-1:0]  dec;

      sample  = '0;
      fired   = '0;
      first   = '0;
      dec     = '0;
      elapsed = CountWidth'(req.elapsed_ms);
      for (int i = 0; i < NumLanes; i++) begin
         sample[i] = req.pressed_buttons[i];
      end
      base   = frozen_ff ? baseline_ff : current_ff;
      rising = sample & ~base;

      current_in  = current_ff;
      baseline_in = baseline_ff;
      frozen_in   = frozen_ff;
      for (int i = 0; i < NumLanes; i++) begin
         count_in[i] = count_ff[i];
         delay_in[i] = delay_ff[i];
      end

      if (req_take && op == OP_DELAY) begin
         for (int i = 0; i < NumLanes; i++) begin
            if (req.delay_button == ButtonWidth'(i)) begin
               delay_in[i] = req.delay_value;
            end
         end
      end else if (req_take) begin
         current_in  = sample;
         baseline_in = base;
         frozen_in   = req.freeze_baseline;
         for (int i = 0; i < NumLanes; i++) begin
            first = {1'b0, delay_ff[i], 1'b0} + CountWidth'(delay_ff[i]);
            if (!sample[i]) begin
               dec = first;
            end else if (count_ff[i] > elapsed) begin
               dec = count_ff[i] - elapsed;
            end else begin
               dec = '0;
            end
            if (rising[i]) begin
               count_in[i] = first;
               fired[i]    = 1'b1;
            end else if (sample[i] && dec == '0) begin
               count_in[i] = CountWidth'(delay_ff[i]);
               fired[i]    = 1'b1;
            end else begin
               count_in[i] = dec;
            end
         end
      end

      if (op == OP_DELAY) begin
         result.repeat_events  = '0;
         result.key_on_events  = '0;
         result.key_off_events = '0;
         result.held_buttons   = current_ff;
      end else begin
         result.repeat_events  = fired;
         result.key_on_events  = rising;
         result.key_off_events = base & ~sample;
         result.held_buttons   = sample;
      end
   end

   // two-deep result buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff    <= '0;
         baseline_ff   <= '0;
         frozen_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < NumLanes; i++) begin
            count_ff[i] <= DefaultCount;
            delay_ff[i] <= DefaultDelay;
         end
      end else begin
         current_ff    <= current_in;
         baseline_ff   <= baseline_in;
         frozen_ff     <= frozen_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int i = 0; i < NumLanes; i++) begin
            count_ff[i] <= count_in[i];
            delay_ff[i] <= delay_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `BTR_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff,
      "skid beat held without an output beat")
   `BTR_ASSERT_NOW(a_on_off_disjoint, out_valid_ff,
      (out_data_ff.key_on_events & out_data_ff.key_off_events) == '0,
      "key-on and key-off set for the same button")
   `BTR_ASSERT_NOW(a_on_fires, out_valid_ff,
      (out_data_ff.key_on_events & ~out_data_ff.repeat_events) == '0,
      "key-on without a fire")
   `BTR_ASSERT_NOW(a_fire_held, out_valid_ff,
      (out_data_ff.repeat_events & ~out_data_ff.held_buttons) == '0,
      "fire on a button not held")
   `BTR_ASSERT_NEXT(a_freeze_follow, req_take && op == OP_POLL,
      frozen_ff == $past(req.freeze_baseline), "freeze flag not taken from poll")

endmodule

[tb/button_typematic_repeat_test.sv]
module button_typematic_repeat_test;
   import btr_pkg::*;

   localparam int NumButtons = 16;
   localparam int FirstFactor = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic req_tuser = OP_POLL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   // predictor state
   logic [SampleWidth-1:0] last_sample;
   logic [SampleWidth-1:0] edge_base;
   logic base_frozen;
   logic [CountWidth-1:0] lane_count [NumButtons];
   logic [DelayWidth-1:0] lane_delay [NumButtons];

   rsp_data_type pending_events[$];
   logic idling = 1'b1;
   int failures = 0;
   int polls_sent = 0;
   int frozen_polls = 0;
   int writes_sent = 0;
   int repeats_due = 0;
   int key_ons_due = 0;
   int key_offs_due = 0;
   int stall_left = 0;

   button_typematic_repeat #(.NUM_BUTTONS(NumButtons)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic rsp_data_type typematic_predict(op_type op, req_data_type d);
      rsp_data_type r;
      logic [SampleWidth-1:0] s;
      int i;
      r = '0;
      if (op == OP_DELAY) begin
         if (d.delay_button < NumButtons) lane_delay[d.delay_button] = d.delay_value;
         r.held_buttons = last_sample;
         return r;
      end
      s = d.pressed_buttons & SampleWidth'((64'd1 << NumButtons) - 1);
      if (!base_frozen) edge_base = last_sample;
      base_frozen = d.freeze_baseline;
      last_sample = s;
      r.key_on_events = s & ~edge_base;
      r.key_off_events = edge_base & ~s;
      r.held_buttons = s;
      for (i = 0; i < NumButtons; i++) begin
         if (!s[i]) begin
            lane_count[i] = CountWidth'(lane_delay[i]) * CountWidth'(FirstFactor);
         end else if (r.key_on_events[i]) begin
            lane_count[i] = CountWidth'(lane_delay[i]) * CountWidth'(FirstFactor);
            r.repeat_events[i] = 1'b1;
         end else begin
            if (lane_count[i] > CountWidth'(d.elapsed_ms))
               lane_count[i] = lane_count[i] - CountWidth'(d.elapsed_ms);
            else
               lane_count[i] = '0;
            if (lane_count[i] == '0) begin
               lane_count[i] = CountWidth'(lane_delay[i]);
               r.repeat_events[i] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic clear_predictor();
      int i;
      last_sample = '0;
      edge_base = '0;
      base_frozen = 1'b0;
      for (i = 0; i < NumButtons; i++) begin
         lane_count[i] = DefaultCount;
         lane_delay[i] = DefaultDelay;
      end
   endtask

   task automatic offer_beat(op_type op, req_data_type d);
      rsp_data_type r;
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      r = typematic_predict(op, d);
      pending_events.push_back(r);
      if (op == OP_DELAY) begin
         writes_sent++;
      end else begin
         polls_sent++;
         if (d.freeze_baseline) frozen_polls++;
      end
      repeats_due += $countones(r.repeat_events);
      key_ons_due += $countones(r.key_on_events);
      key_offs_due += $countones(r.key_off_events);
   endtask

   task automatic send_poll(logic [15:0] pressed, logic [15:0] elapsed, logic freeze);
      req_data_type d;
      d = '0;
      d.pressed_buttons = pressed;
      d.elapsed_ms = elapsed;
      d.freeze_baseline = freeze;
      offer_beat(OP_POLL, d);
   endtask

   task automatic send_delay(logic [3:0] button, logic [15:0] value);
      req_data_type d;
      d = '0;
      d.delay_button = button;
      d.delay_value = value;
      offer_beat(OP_DELAY, d);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic test_press_and_hold();
      send_poll(16'h0000, 16'h0000, 1'b0);
      send_poll(16'hFFFF, 16'hFFFF, 1'b0);
      send_poll(16'hFFFF, 16'd599, 1'b0);
      send_poll(16'hFFFF, 16'd1, 1'b0);
      send_delay(4'd5, 16'd200);
      send_poll(16'hFFFF, 16'hFFFF, 1'b0);
      send_poll(16'h0000, 16'd10, 1'b0);
   endtask

   task automatic test_delay_writes();
      send_delay(4'd0, 16'h0000);
      send_delay(4'd15, 16'hFFFF);
      send_delay(4'd3, 16'd1);
      send_poll(16'h8009, 16'd10, 1'b0);
      send_poll(16'h8009, 16'd0, 1'b0);
      send_poll(16'h8009, 16'd3, 1'b0);
      send_poll(16'h8009, 16'hFFFF, 1'b0);
   endtask

   task automatic test_freeze_baseline();
      send_poll(16'h0001, 16'd5, 1'b0);
      send_poll(16'h0003, 16'd5, 1'b1);
      send_poll(16'h0003, 16'd5, 1'b1);
      send_poll(16'h0000, 16'd5, 1'b0);
      send_poll(16'h0002, 16'd5, 1'b0);
      send_poll(16'h0000, 16'd5, 1'b0);
   endtask

   task automatic test_random_polls(int count);
      req_data_type d;
      logic [15:0] held;
      logic freeze;
      int k;
      held = '0;
      freeze = 1'b0;
      for (k = 0; k < count; k++) begin
         if (k == count / 2) wait_for_drain();
         if (k == count - 100) idling = 1'b0;
         d.pad = '0;
         d.pressed_buttons = 16'($urandom);
         d.elapsed_ms = 16'($urandom);
         d.freeze_baseline = 1'($urandom);
         d.delay_button = 4'($urandom);
         d.delay_value = 16'($urandom);
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
               0: d.delay_value = 16'h0000;
               1: d.delay_value = 16'hFFFF;
               2: ;
               default: d.delay_value = 16'($urandom_range(1, 400));
            endcase
            offer_beat(OP_DELAY, d);
         end else begin
            case ($urandom_range(0, 9))
               0, 1: held = held ^ (16'd1 << $urandom_range(0, 15));
               2: held = 16'($urandom);
               3: held = '0;
               default: ;
            endcase
            if ($urandom_range(0, 11) == 0) freeze = ~freeze;
            case ($urandom_range(0, 9))
               0: d.elapsed_ms = 16'h0000;
               1: d.elapsed_ms = 16'hFFFF;
               2: ;
               default: d.elapsed_ms = 16'($urandom_range(1, 250));
            endcase
            d.pressed_buttons = held;
            d.freeze_baseline = freeze;
            offer_beat(OP_POLL, d);
         end
      end
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_data_type want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (pending_events.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_events.pop_front();
            check_field("repeat_events", want.repeat_events, got.repeat_events);
            check_field("key_on_events", want.key_on_events, got.key_on_events);
            check_field("key_off_events", want.key_off_events, got.key_off_events);
            check_field("held_buttons", want.held_buttons, got.held_buttons);
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      clear_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_press_and_hold();
      test_delay_writes();
      test_freeze_baseline();
      test_random_polls(600);
      wait_for_drain();
      repeat (4) @(posedge clock);
      $display("covered %0d polls (%0d frozen) and %0d delay writes", polls_sent,
               frozen_polls, writes_sent);
      $display("predicted %0d repeat firings, %0d key-on and %0d key-off events",
               repeats_due, key_ons_due, key_offs_due);
      if (failures == 0 && pending_events.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
